### rtl/core/tet_pkg.sv
package tet_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [2:0] CMD_ADD_ONESHOT  = 3'd0;
  localparam logic [2:0] CMD_ADD_PERIODIC = 3'd1;
  localparam logic [2:0] CMD_REMOVE       = 3'd2;
  localparam logic [2:0] CMD_STEP         = 3'd3;
  localparam logic [2:0] CMD_QUERY        = 3'd4;

  localparam logic [1:0] KIND_ADD_ACK = 2'd0;
  localparam logic [1:0] KIND_FIRED   = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_STEP   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] deadline;
    logic [47:0] now;
    logic [31:0] reload_period;
    logic [31:0] timer_id;
    logic [31:0] user_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] result_id;
    logic [31:0] fired_tag;
    logic        is_expired;
    logic        status;
    logic        last;
  } out_item_t;

  // decoded command as queued between front and engine
  typedef struct packed {
    op_t         op;
    logic [47:0] time_val;
    logic [31:0] interval;
    logic [31:0] id;
    logic [31:0] tag;
  } work_t;

  function automatic logic [31:0] next_id(input logic [31:0] c);
    next_id = (c == 32'hFFFF_FFFF) ? 32'd1 : c + 32'd1;
  endfunction

  function automatic out_item_t make_out(input logic [1:0] kind, input logic [31:0] rid,
                                         input logic [31:0] tag, input logic expd,
                                         input logic st, input logic lst);
    out_item_t o;
    o.kind       = kind;
    o.result_id  = rid;
    o.fired_tag  = tag;
    o.is_expired = expd;
    o.status     = st;
    o.last       = lst;
    make_out     = o;
  endfunction

endpackage

### rtl/core/tet_front.sv
module tet_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  tet_pkg::in_item_t in_data,
  input  logic             f_full,
  output logic             f_push,
  output tet_pkg::work_t   f_item
);

  logic cmd_ok;

  // unknown commands are taken and dropped here
  always_comb begin
    cmd_ok          = 1'b1;
    f_item.op       = tet_pkg::OP_ADD;
    f_item.time_val = in_data.deadline;
    f_item.interval = 32'd0;
    f_item.id       = in_data.timer_id;
    f_item.tag      = in_data.user_tag;
    unique case (in_data.command)
      tet_pkg::CMD_ADD_ONESHOT: begin
        f_item.op = tet_pkg::OP_ADD;
      end
      tet_pkg::CMD_ADD_PERIODIC: begin
        f_item.op       = tet_pkg::OP_ADD;
        f_item.interval = in_data.reload_period;
      end
      tet_pkg::CMD_REMOVE: begin
        f_item.op = tet_pkg::OP_REMOVE;
      end
      tet_pkg::CMD_STEP: begin
        f_item.op       = tet_pkg::OP_STEP;
        f_item.time_val = in_data.now;
      end
      tet_pkg::CMD_QUERY: begin
        f_item.op = tet_pkg::OP_QUERY;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  assign in_ready = !f_full;
  assign f_push   = in_valid && in_ready && cmd_ok;

endmodule

### rtl/core/tet_fifo.sv
module tet_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tet_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output tet_pkg::work_t q_item
);

  localparam int PW = (tet_pkg::QUEUE_DEPTH > 1) ? $clog2(tet_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(tet_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(tet_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(tet_pkg::QUEUE_DEPTH);

  tet_pkg::work_t mem_r [tet_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/core/tet_engine.sv
module tet_engine #(
  parameter int TIMER_SLOTS = tet_pkg::TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tet_pkg::work_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tet_pkg::out_item_t out_data
);

  localparam int IDXW = $clog2(TIMER_SLOTS);
  localparam int NW   = $clog2(tet_pkg::MAX_RESULTS + 1);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(TIMER_SLOTS - 1);
  localparam logic [NW-1:0]   N_MAX    = NW'(tet_pkg::MAX_RESULTS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_IDSCAN = 5'b00010,
    ST_FIND   = 5'b00100,
    ST_STEP   = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  // slot table
  logic [31:0] slot_id_r  [TIMER_SLOTS];
  logic [47:0] slot_exp_r [TIMER_SLOTS];
  logic [31:0] slot_ivl_r [TIMER_SLOTS];
  logic [31:0] slot_tag_r [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] valid_r, valid_nxt, done_r, done_nxt;

  state_t         state_r, state_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt, free_r, free_nxt;
  tet_pkg::work_t cur_r, cur_nxt;
  logic [31:0]    cand_r, cand_nxt, counter_r, counter_nxt;
  logic [NW-1:0]  n_r, n_nxt;

  logic           best_v_r, best_v_nxt;
  logic [IDXW-1:0] best_idx_r, best_idx_nxt;
  logic [47:0]    best_exp_r, best_exp_nxt;
  logic [31:0]    best_id_r, best_id_nxt, best_tag_r, best_tag_nxt, best_ivl_r, best_ivl_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [31:0]    pend_id_r, pend_id_nxt, pend_tag_r, pend_tag_nxt;

  tet_pkg::out_item_t resp_r, resp_nxt, out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // table write strobes
  logic            add_wr;
  logic            exp_wr;
  logic [IDXW-1:0] exp_wr_idx;
  logic [47:0]     exp_wr_val;

  // scan element
  logic            cur_vld, id_hit, due, better, can_push, push_en;
  logic [31:0]     sid, key;
  logic [47:0]     sexp;
  logic            f_v;
  logic [IDXW-1:0] f_idx;
  logic [47:0]     f_exp;
  logic [31:0]     f_id, f_tag, f_ivl;
  tet_pkg::out_item_t push_data;

  logic            free_found;
  logic [IDXW-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDXW'(i);
      end
    end
  end

  assign cur_vld = valid_r[idx_r];
  assign sid     = slot_id_r[idx_r];
  assign sexp    = slot_exp_r[idx_r];
  assign key     = (state_r == ST_IDSCAN) ? cand_r : cur_r.id;
  assign id_hit  = cur_vld && (sid == key);
  assign due     = cur_vld && !done_r[idx_r] && (sexp <= cur_r.time_val);
  assign better  = due && (!best_v_r || (sexp < best_exp_r) ||
                           ((sexp == best_exp_r) && (sid < best_id_r)));
  assign f_v     = best_v_r || better;
  assign f_idx   = better ? idx_r : best_idx_r;
  assign f_exp   = better ? sexp : best_exp_r;
  assign f_id    = better ? sid : best_id_r;
  assign f_tag   = better ? slot_tag_r[idx_r] : best_tag_r;
  assign f_ivl   = better ? slot_ivl_r[idx_r] : best_ivl_r;
  assign can_push = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    free_nxt     = free_r;
    cur_nxt      = cur_r;
    cand_nxt     = cand_r;
    counter_nxt  = counter_r;
    n_nxt        = n_r;
    valid_nxt    = valid_r;
    done_nxt     = done_r;
    best_v_nxt   = best_v_r;
    best_idx_nxt = best_idx_r;
    best_exp_nxt = best_exp_r;
    best_id_nxt  = best_id_r;
    best_tag_nxt = best_tag_r;
    best_ivl_nxt = best_ivl_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_tag_nxt = pend_tag_r;
    resp_nxt     = resp_r;
    q_pop        = 1'b0;
    push_en      = 1'b0;
    push_data    = resp_r;
    add_wr       = 1'b0;
    exp_wr       = 1'b0;
    exp_wr_idx   = f_idx;
    exp_wr_val   = f_exp + {16'd0, f_ivl};

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          idx_nxt = '0;
          unique case (q_item.op)
            tet_pkg::OP_ADD: begin
              if (!free_found) begin
                resp_nxt  = tet_pkg::make_out(tet_pkg::KIND_ADD_ACK, 32'd0, 32'd0,
                                              1'b0, 1'b1, 1'b1);
                state_nxt = ST_RESP;
              end else begin
                free_nxt  = free_idx;
                cand_nxt  = tet_pkg::next_id(counter_r);
                state_nxt = ST_IDSCAN;
              end
            end
            tet_pkg::OP_REMOVE, tet_pkg::OP_QUERY: begin
              state_nxt = ST_FIND;
            end
            tet_pkg::OP_STEP: begin
              done_nxt   = '0;
              n_nxt      = '0;
              best_v_nxt = 1'b0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_STEP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_IDSCAN: begin
        if (id_hit) begin
          // candidate taken, try the next one from the top
          cand_nxt = tet_pkg::next_id(cand_r);
          idx_nxt  = '0;
        end else if (idx_r == IDX_LAST) begin
          add_wr            = 1'b1;
          valid_nxt[free_r] = 1'b1;
          counter_nxt       = cand_r;
          resp_nxt  = tet_pkg::make_out(tet_pkg::KIND_ADD_ACK, cand_r, 32'd0,
                                        1'b0, 1'b0, 1'b1);
          state_nxt = ST_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIND: begin
        if (id_hit || (idx_r == IDX_LAST)) begin
          if (cur_r.op == tet_pkg::OP_REMOVE) begin
            if (id_hit) begin
              valid_nxt[idx_r] = 1'b0;
            end
            state_nxt = ST_IDLE;
          end else begin
            resp_nxt  = tet_pkg::make_out(tet_pkg::KIND_QUERY, cur_r.id, 32'd0,
                                          !id_hit, 1'b0, 1'b1);
            state_nxt = ST_RESP;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_STEP: begin
        if (idx_r != IDX_LAST) begin
          best_v_nxt   = f_v;
          best_idx_nxt = f_idx;
          best_exp_nxt = f_exp;
          best_id_nxt  = f_id;
          best_tag_nxt = f_tag;
          best_ivl_nxt = f_ivl;
          idx_nxt      = idx_r + 1'b1;
        end else if (f_v) begin
          if (!pend_v_r || can_push) begin
            if (pend_v_r) begin
              push_en   = 1'b1;
              push_data = tet_pkg::make_out(tet_pkg::KIND_FIRED, pend_id_r, pend_tag_r,
                                            1'b0, 1'b0, 1'b0);
            end
            if (f_ivl != 32'd0) begin
              exp_wr = 1'b1;
            end else begin
              valid_nxt[f_idx] = 1'b0;
            end
            done_nxt[f_idx] = 1'b1;
            n_nxt           = n_r + 1'b1;
            if (n_r + 1'b1 == N_MAX) begin
              resp_nxt  = tet_pkg::make_out(tet_pkg::KIND_FIRED, f_id, f_tag,
                                            1'b0, 1'b0, 1'b1);
              state_nxt = ST_RESP;
            end else begin
              pend_v_nxt   = 1'b1;
              pend_id_nxt  = f_id;
              pend_tag_nxt = f_tag;
              best_v_nxt   = 1'b0;
              idx_nxt      = '0;
            end
          end
        end else if (pend_v_r) begin
          resp_nxt  = tet_pkg::make_out(tet_pkg::KIND_FIRED, pend_id_r, pend_tag_r,
                                        1'b0, 1'b0, 1'b1);
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (can_push) begin
          push_en   = 1'b1;
          push_data = resp_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push_en) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_data;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_nxt       = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      counter_r   <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      counter_r   <= counter_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      best_v_r    <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    free_r     <= free_nxt;
    cur_r      <= cur_nxt;
    cand_r     <= cand_nxt;
    n_r        <= n_nxt;
    done_r     <= done_nxt;
    best_idx_r <= best_idx_nxt;
    best_exp_r <= best_exp_nxt;
    best_id_r  <= best_id_nxt;
    best_tag_r <= best_tag_nxt;
    best_ivl_r <= best_ivl_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_tag_r <= pend_tag_nxt;
    resp_r     <= resp_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (add_wr) begin
      slot_id_r[free_r]  <= cand_r;
      slot_exp_r[free_r] <= cur_r.time_val;
      slot_ivl_r[free_r] <= cur_r.interval;
      slot_tag_r[free_r] <= cur_r.tag;
    end else if (exp_wr) begin
      slot_exp_r[exp_wr_idx] <= exp_wr_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/timer_expiry_table.sv
// channel  | ports                       | role
// ---------+-----------------------------+--------------------------------------
// input    | in_valid in_ready in_data   | one command transaction (in_item_t)
// result   | out_valid out_ready out_data| acks, fired timers, query answers
//
// add: scans all slots, from the top again after each id collision, one slot
//   compared per cycle; remove and query scan until the id or the last slot
// step: one slot scan per due timer, at most MAX_RESULTS, plus a final pass
//   unless that limit is reached; the slot scan in the engine sets these costs
// reset: rst_n synchronous, clears slot valid bits, id counter, queue and state
// a two-entry command queue takes input until full while the engine or the
//   output register is stalled; the engine waits only to push into a full output
module timer_expiry_table #(
  parameter int TIMER_SLOTS = tet_pkg::TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tet_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tet_pkg::out_item_t out_data
);

  // front to queue
  logic           f_push, f_full;
  tet_pkg::work_t f_item;

  // queue to engine
  logic           q_valid, q_pop;
  tet_pkg::work_t q_item;

  // decode and drop unknown commands
  tet_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .f_full   (f_full),
    .f_push   (f_push),
    .f_item   (f_item)
  );

  // short queue decoupling front from engine
  tet_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .full      (f_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // slot table, id allocation, expiry selection and result register
  tet_engine #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a full queue must hold off the input side
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    f_full |-> !in_ready) else $error("input taken while queue full");

  // an add acknowledge is always the only result of its transaction
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == tet_pkg::KIND_ADD_ACK) |-> out_data.last)
    else $error("add acknowledge without last");

  // a refused add hands out no id
  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.result_id == 32'd0))
    else $error("refused add carries an id");
`endif

endmodule
